### src/irfe_pkg.sv
`timescale 1ns / 1ps
// Package for the infrared remote frame encoder.
// Holds the microcode types, the duration constants and the program table.
// No dependencies.
package irfe_pkg;

    localparam int DUR_W = 15;

    localparam logic [DUR_W-1:0] DUR_0    = 15'd0;
    localparam logic [DUR_W-1:0] DUR_560  = 15'd560;
    localparam logic [DUR_W-1:0] DUR_600  = 15'd600;
    localparam logic [DUR_W-1:0] DUR_1200 = 15'd1200;
    localparam logic [DUR_W-1:0] DUR_1690 = 15'd1690;
    localparam logic [DUR_W-1:0] DUR_2400 = 15'd2400;
    localparam logic [DUR_W-1:0] DUR_4500 = 15'd4500;
    localparam logic [DUR_W-1:0] DUR_9000 = 15'd9000;

    // Bit counts minus one, loaded into the down counter.
    localparam logic [4:0] NEC_BITS_M1  = 5'd31;
    localparam logic [4:0] SIRC_BITS_M1 = 5'd11;

    localparam logic PROTO_NEC  = 1'b0;
    localparam logic PROTO_SIRC = 1'b1;

    // Program addresses.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEC_PRE,
        ST_NEC_BIT,
        ST_NEC_END,
        ST_SIRC_PRE,
        ST_SIRC_BIT
    } t_step;

    // Duration selects for the mark and space fields.
    typedef enum logic [2:0] {
        D_ZERO,
        D_560,
        D_600,
        D_2400,
        D_4500,
        D_9000,
        D_NEC_BIT,
        D_SIRC_BIT
    } t_dur;

    typedef enum logic [1:0] {
        L_ZERO,
        L_ONE,
        L_CNT_ZERO
    } t_lastsel;

    typedef enum logic [1:0] {
        J_NEXT,
        J_START,
        J_LOOP,
        J_GOTO
    } t_jump;

    // One control word of the program.
    typedef struct packed {
        logic     emit;
        t_dur     mark_sel;
        t_dur     space_sel;
        t_lastsel last_sel;
        logic     shift;
        t_jump    jump;
        t_step    target;
    } t_uword;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic cnt_zero;
    } t_dp_status;

    // The microprogram. J_START waits for a word and branches on the protocol,
    // J_LOOP repeats the step until the bit counter runs out.
    function automatic t_uword ucode_rom(input t_step pc);
        t_uword w;
        w = '{1'b0, D_ZERO, D_ZERO, L_ZERO, 1'b0, J_GOTO, ST_IDLE};
        case (pc)
            ST_IDLE:     w = '{1'b0, D_ZERO, D_ZERO, L_ZERO, 1'b0, J_START, ST_SIRC_PRE};
            ST_NEC_PRE:  w = '{1'b1, D_9000, D_4500, L_ZERO, 1'b0, J_NEXT, ST_NEC_BIT};
            ST_NEC_BIT:  w = '{1'b1, D_560, D_NEC_BIT, L_ZERO, 1'b1, J_LOOP, ST_NEC_END};
            ST_NEC_END:  w = '{1'b1, D_560, D_ZERO, L_ONE, 1'b0, J_GOTO, ST_IDLE};
            ST_SIRC_PRE: w = '{1'b1, D_2400, D_600, L_ZERO, 1'b0, J_NEXT, ST_SIRC_BIT};
            ST_SIRC_BIT: w = '{1'b1, D_SIRC_BIT, D_600, L_CNT_ZERO, 1'b1, J_LOOP, ST_IDLE};
            default:     w = '{1'b0, D_ZERO, D_ZERO, L_ZERO, 1'b0, J_GOTO, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

### src/irfe_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program table lookup and jump logic.
// Depends on irfe_pkg.
module irfe_seq
    import irfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_protocol,
    input  t_dp_status i_status,
    output t_uword     o_uword,
    output logic       o_load,
    output logic       o_busy
);

    t_step  r_pc;
    t_step  n_pc;
    t_uword w_uword;

    assign w_uword = ucode_rom(r_pc);
    assign o_uword = w_uword;
    assign o_busy  = (r_pc != ST_IDLE);
    assign o_load  = i_start && (r_pc == ST_IDLE);

    always_comb begin
        n_pc = r_pc;
        case (w_uword.jump)
            J_NEXT: begin
                n_pc = t_step'(3'(r_pc + 3'd1));
            end
            J_START: begin
                if (i_start) begin
                    n_pc = (i_protocol == PROTO_SIRC) ? w_uword.target : ST_NEC_PRE;
                end
            end
            J_LOOP: begin
                if (i_status.cnt_zero) begin
                    n_pc = w_uword.target;
                end
            end
            J_GOTO: begin
                n_pc = w_uword.target;
            end
            default: begin
                n_pc = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

### src/irfe_dp.sv
`timescale 1ns / 1ps
// Datapath: data shift register, bit counter and the registered result word.
// Depends on irfe_pkg; driven by the control word from irfe_seq.
module irfe_dp
    import irfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_protocol,
    input  logic [7:0]       i_address,
    input  logic [7:0]       i_command,
    input  t_uword           i_uword,
    output t_dp_status       o_status,
    output logic             o_stb,
    output logic [DUR_W-1:0] o_mark_us,
    output logic [DUR_W-1:0] o_space_us,
    output logic             o_last
);

    logic [31:0]      r_word;
    logic [4:0]       r_cnt;
    logic             r_stb;
    logic [DUR_W-1:0] r_mark;
    logic [DUR_W-1:0] r_space;
    logic             r_last;
    logic             w_bit;
    logic             w_last;

    function automatic logic [DUR_W-1:0] dur_sel(input t_dur sel, input logic b);
        logic [DUR_W-1:0] d;
        d = DUR_0;
        case (sel)
            D_ZERO:     d = DUR_0;
            D_560:      d = DUR_560;
            D_600:      d = DUR_600;
            D_2400:     d = DUR_2400;
            D_4500:     d = DUR_4500;
            D_9000:     d = DUR_9000;
            D_NEC_BIT:  d = b ? DUR_1690 : DUR_560;
            D_SIRC_BIT: d = b ? DUR_1200 : DUR_600;
            default:    d = DUR_0;
        endcase
        return d;
    endfunction

    assign w_bit             = r_word[0];
    assign o_status.cnt_zero = (r_cnt == 5'd0);

    always_comb begin
        case (i_uword.last_sel)
            L_ZERO:     w_last = 1'b0;
            L_ONE:      w_last = 1'b1;
            L_CNT_ZERO: w_last = (r_cnt == 5'd0);
            default:    w_last = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_protocol == PROTO_SIRC) begin
                r_word <= {20'd0, i_address[4:0], i_command[6:0]};
                r_cnt  <= SIRC_BITS_M1;
            end else begin
                r_word <= {~i_command, i_command, ~i_address, i_address};
                r_cnt  <= NEC_BITS_M1;
            end
        end else if (i_uword.shift) begin
            r_word <= {1'b0, r_word[31:1]};
            r_cnt  <= r_cnt - 5'd1;
        end
        r_mark  <= dur_sel(i_uword.mark_sel, w_bit);
        r_space <= dur_sel(i_uword.space_sel, w_bit);
        r_last  <= w_last;
        if (!i_rst_n) begin
            r_stb <= 1'b0;
        end else begin
            r_stb <= i_uword.emit;
        end
    end

    assign o_stb      = r_stb;
    assign o_mark_us  = r_mark;
    assign o_space_us = r_space;
    assign o_last     = r_last;

endmodule

### src/ir_remote_frame_encoder_core.sv
`timescale 1ns / 1ps
// Infrared remote frame encoder, top level. Depends on irfe_pkg, irfe_seq, irfe_dp.
// The first pair is registered at the edge after the accepting edge and is shown for
// the cycle that follows. Then one pair per cycle, 34 for NEC and 13 for SIRC. A new
// word is taken only in the idle step, after one step per pair; busy is low again
// when the last pair is shown. Sync reset selects NEC.
module ir_remote_frame_encoder_core
    import irfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             start,
    output logic             busy,
    input  logic [7:0]       i_address,
    input  logic [7:0]       i_command,
    output logic             o_result_stb,
    output logic [DUR_W-1:0] o_mark_us,
    output logic [DUR_W-1:0] o_space_us,
    output logic             o_last
);

    // The user must write the protocol register only while the encoder is idle (not
    // enforced here), so the sequencer and datapath can read it directly throughout a frame.
    logic       r_protocol;
    t_uword     w_uword;
    t_dp_status w_status;
    logic       w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol <= PROTO_NEC;
        end else if (i_cfg_wr_en) begin
            r_protocol <= i_cfg_wr_data;
        end
    end

    // The sequencer steps through the program table; each control word selects
    // the durations of one pair and whether the data word shifts.
    irfe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_protocol (r_protocol),
        .i_status   (w_status),
        .o_uword    (w_uword),
        .o_load     (w_load),
        .o_busy     (busy)
    );

    // The datapath holds the frame bits, least significant first, and registers
    // each pair as it is produced.
    irfe_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_protocol (r_protocol),
        .i_address  (i_address),
        .i_command  (i_command),
        .i_uword    (w_uword),
        .o_status   (w_status),
        .o_stb      (o_result_stb),
        .o_mark_us  (o_mark_us),
        .o_space_us (o_space_us),
        .o_last     (o_last)
    );

    // An accepted word keeps the encoder busy on the next cycle.
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("encoder not busy after accepting a word");

    // When the final pair is shown the program has already returned to idle.
    a_last_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_stb && o_last) |-> !busy)
        else $error("still busy on the final pair");

    // Any pair other than the final one is shown while a frame is in progress.
    a_mid_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_stb && !o_last) |-> busy)
        else $error("pair shown while idle");

endmodule

### tb/ir_remote_frame_encoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the infrared remote frame encoder core.
// Drives address/command words under NEC and SIRC settings and checks every
// emitted mark/space pair against a frame builder kept here. Depends on irfe_pkg.
module ir_remote_frame_encoder_core_tb;
    import irfe_pkg::*;

    // A generous cycle budget. The slowest correct run is roughly 520 words, each
    // waiting out its idle gap and then a whole frame in the block, plus the pauses
    // around the register writes.
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned RAND_PHASES = 8;
    localparam int unsigned WORDS_PER_PHASE = 62;

    // One mark/space pair as the block shows it on its result ports.
    typedef struct {
        logic [DUR_W-1:0] mark_us;
        logic [DUR_W-1:0] space_us;
        logic             last;
    } t_ir_pair;

    // One input word plus the number of idle cycles that go before it.
    typedef struct {
        logic [7:0]  address;
        logic [7:0]  command;
        int unsigned gap;
    } t_ir_word;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic             i_cfg_wr_data = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [7:0]       i_address = 8'h00;
    logic [7:0]       i_command = 8'h00;
    logic             o_result_stb;
    logic [DUR_W-1:0] o_mark_us;
    logic [DUR_W-1:0] o_space_us;
    logic             o_last;

    t_ir_word    pending_words[$];
    t_ir_pair    expected_pairs[$];

    // The protocol setting the block should hold right now. It follows the
    // write port at the clock edge, just as the register inside the block does.
    logic        protocol_sel = PROTO_NEC;

    // Set for one cycle after an edge at which the block took a word.
    logic        word_taken = 1'b0;

    // Driver state: whether a word is being held (in its gap or on the ports).
    bit          driver_busy = 1'b0;
    t_ir_word    cur_word;
    int unsigned gap_left = 0;

    int unsigned cycle_count = 0;
    int unsigned fault_count = 0;
    int unsigned pairs_checked = 0;
    int unsigned nec_frames = 0;
    int unsigned sirc_frames = 0;

    ir_remote_frame_encoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .start         (start),
        .busy          (busy),
        .i_address     (i_address),
        .i_command     (i_command),
        .o_result_stb  (o_result_stb),
        .o_mark_us     (o_mark_us),
        .o_space_us    (o_space_us),
        .o_last        (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Builds the full frame for one word and queues its pairs in sending order.
    // NEC sends address, inverted address, command and inverted command, least
    // significant bit first, with the bit value in the space; SIRC sends seven
    // command bits then five address bits with the bit value in the mark, and
    // its closing pair is the last data bit rather than a zero-space stop pair.
    task automatic predict_frame(input logic proto, input logic [7:0] addr,
                                 input logic [7:0] cmd);
        logic [31:0] nec_bits;
        logic [11:0] sirc_bits;
        if (proto == PROTO_SIRC) begin
            sirc_bits = {addr[4:0], cmd[6:0]};
            expected_pairs.push_back(t_ir_pair'{DUR_2400, DUR_600, 1'b0});
            for (int b = 0; b < 12; b++) begin
                expected_pairs.push_back(t_ir_pair'{sirc_bits[b] ? DUR_1200 : DUR_600,
                                                    DUR_600, (b == 11)});
            end
            sirc_frames++;
        end else begin
            nec_bits = {~cmd, cmd, ~addr, addr};
            expected_pairs.push_back(t_ir_pair'{DUR_9000, DUR_4500, 1'b0});
            for (int b = 0; b < 32; b++) begin
                expected_pairs.push_back(t_ir_pair'{DUR_560,
                                                    nec_bits[b] ? DUR_1690 : DUR_560,
                                                    1'b0});
            end
            expected_pairs.push_back(t_ir_pair'{DUR_560, DUR_0, 1'b1});
            nec_frames++;
        end
    endtask

    // Counts a failure; only the first few are described in the log.
    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("[%0t] error: %s", $realtime, what);
        end
    endtask

    // Monitor. Everything is sampled at the rising edge, where the block also
    // samples its inputs. A finished pair is compared before a newly taken word
    // is predicted, although the two never compete for the queue head anyway:
    // the new frame's first pair must pass the step register and then the result register.
    always @(posedge i_clk) begin
        t_ir_pair want;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
            protocol_sel <= PROTO_NEC;
        end else begin
            if (o_result_stb) begin
                if (expected_pairs.size() == 0) begin
                    note_fault($sformatf("pair %0d/%0d last=%0b with no frame pending",
                                         o_mark_us, o_space_us, o_last));
                end else begin
                    want = expected_pairs.pop_front();
                    pairs_checked++;
                    if (o_mark_us !== want.mark_us || o_space_us !== want.space_us
                            || o_last !== want.last) begin
                        note_fault($sformatf(
                            "pair mismatch: expected %0d/%0d last=%0b, got %0d/%0d last=%0b",
                            want.mark_us, want.space_us, want.last,
                            o_mark_us, o_space_us, o_last));
                    end
                end
            end
            if (start && !busy) begin
                predict_frame(protocol_sel, i_address, i_command);
            end
            if (i_cfg_wr_en) begin
                protocol_sel <= i_cfg_wr_data;
            end
            word_taken <= start && !busy;
        end
    end

    // Driver. Works at the falling edge so the ports are stable well before the
    // block samples them. A word first sits out its gap with start low, then is
    // shown with start high until the block takes it. With a zero gap the next
    // word follows straight on and start simply stays high. Each port gets one
    // assignment per edge, so there is never a low-then-high pair in one step.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && word_taken) begin
                driver_busy = 1'b0;
            end
            if (!driver_busy && pending_words.size() != 0) begin
                cur_word = pending_words.pop_front();
                gap_left = cur_word.gap;
                driver_busy = 1'b1;
            end
            if (driver_busy && gap_left == 0) begin
                start <= 1'b1;
                i_address <= cur_word.address;
                i_command <= cur_word.command;
            end else begin
                if (driver_busy) begin
                    gap_left--;
                end
                // Junk on the data ports while idle shows that the block
                // latches its word at the accepting edge and nowhere else.
                start <= 1'b0;
                i_address <= 8'($urandom);
                i_command <= 8'($urandom);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] error: cycle limit reached with %0d pairs outstanding",
                     $realtime, expected_pairs.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_word(input logic [7:0] addr, input logic [7:0] cmd,
                              input int unsigned gap);
        pending_words.push_back(t_ir_word'{addr, cmd, gap});
    endtask

    // Returns once every queued word has been taken and its whole frame has
    // come out. Every word yields pairs, so an empty expectation queue means
    // the block is back in its idle step.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || driver_busy || expected_pairs.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // Register write, done only while the block is idle.
    task automatic set_protocol(input logic proto);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= proto;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= 1'b0;
    endtask

    // Directed words shared by both formats: all-zero and all-one bytes,
    // alternating bit patterns and single set bits at each end of the bytes.
    // Under SIRC the all-one and top-bit cases show the unused high bits of
    // the address and command being ignored.
    task automatic queue_directed();
        queue_word(8'h00, 8'h00, 0);
        queue_word(8'hFF, 8'hFF, 0);
        queue_word(8'hAA, 8'h55, 3);
        queue_word(8'h55, 8'hAA, 0);
        queue_word(8'h01, 8'h80, 15);
        queue_word(8'h80, 8'h01, 0);
        queue_word(8'h1F, 8'h7F, 1);
        queue_word(8'hE0, 8'h80, 0);
        queue_word(8'h10, 8'h40, 0);
        queue_word(8'($urandom), 8'($urandom), $urandom_range(0, 15));
        queue_word(8'($urandom), 8'($urandom), 0);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic        proto;
        bit          no_gaps;
        int unsigned gap;

        // Synchronous reset held low from the start, then released once at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The block comes out of reset in NEC mode; run the directed set
        // there first without touching the register, then again under SIRC.
        queue_directed();
        wait_idle();
        set_protocol(PROTO_SIRC);
        queue_directed();
        wait_idle();

        // Random phases alternate the format. One phase runs with no idle
        // cycles at all so that words arrive back to back; the others mix
        // random gaps with occasional zero-gap runs.
        for (int p = 0; p < RAND_PHASES; p++) begin
            proto = (p % 2 == 0) ? PROTO_NEC : PROTO_SIRC;
            no_gaps = (p == 3);
            set_protocol(proto);
            for (int w = 0; w < WORDS_PER_PHASE; w++) begin
                if (no_gaps || $urandom_range(0, 3) == 0) begin
                    gap = 0;
                end else begin
                    gap = $urandom_range(0, 15);
                end
                queue_word(pick_byte(), pick_byte(), gap);
            end
            wait_idle();
        end

        // Let a few more cycles pass to catch any stray pair, then close out.
        repeat (40) @(negedge i_clk);
        if (expected_pairs.size() != 0) begin
            note_fault($sformatf("%0d pairs never arrived", expected_pairs.size()));
        end

        $display("Checked %0d pairs from %0d NEC and %0d SIRC frames over %0d cycles.",
                 pairs_checked, nec_frames, sirc_frames, cycle_count);
        $display("Protocol register toggled across %0d phases; %0d failures seen.",
                 RAND_PHASES + 2, fault_count);
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
src/irfe_pkg.sv
src/irfe_seq.sv
src/irfe_dp.sv
src/ir_remote_frame_encoder_core.sv
tb/ir_remote_frame_encoder_core_tb.sv
